/* src/ctf_pkg.sv */
// shared types, constants and functions of the torque cut gateway filter
package ctf_pkg;

  localparam int ID_W    = 11;
  localparam int LEN_W   = 4;
  localparam int BUS_W   = 2;
  localparam int PAY_W   = 64;
  localparam int AGE_W   = 16;
  localparam int POLY_W  = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;

  localparam logic [BUS_W-1:0] BUS_PT  = 2'd0;
  localparam logic [BUS_W-1:0] BUS_CTL = 2'd1;
  localparam logic [BUS_W-1:0] BUS_DU  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLY    = 1'b1;

  localparam logic [AGE_W-1:0]  TIMEOUT_RST = 16'd150;
  localparam logic [POLY_W-1:0] POLY_RST    = 8'hD5;
  localparam logic [AGE_W-1:0]  AGE_STALE   = 16'hFFFF;
  localparam logic [7:0]        CRC_INIT    = 8'hFF;

  localparam logic [ID_W-1:0] ID_RELAY_A = 11'h696;
  localparam logic [ID_W-1:0] ID_RELAY_B = 11'h697;
  localparam logic [ID_W-1:0] ID_CUT     = 11'h201;
  localparam logic [ID_W-1:0] ID_HV_CMD  = 11'h397;
  localparam logic [ID_W-1:0] ID_DI      = 11'h334;
  localparam logic [ID_W-1:0] ID_PWR     = 11'h268;
  localparam logic [ID_W-1:0] ID_DIAG_IN  = 11'h108;
  localparam logic [ID_W-1:0] ID_DIAG_OUT = 11'h107;

  localparam logic [LEN_W-1:0] LEN_CUT = 4'd3;
  localparam logic [LEN_W-1:0] LEN_HV  = 4'd4;
  localparam logic [LEN_W-1:0] LEN_DI  = 4'd8;
  localparam logic [LEN_W-1:0] LEN_PWR = 4'd5;

  localparam logic [7:0] HV_HDR      = 8'h39;
  localparam logic [7:0] REQ_SET     = 8'h02;
  localparam logic [7:0] REQ_CLR     = 8'h03;
  localparam logic [7:0] DI_SUM_BIAS = 8'h37;
  localparam logic [7:0] PWR_LIMIT   = 8'd100;

  typedef struct packed {
    logic precharge;
    logic negative;
    logic positive;
    logic clamp;
  } stat_t;

  typedef struct packed {
    logic             send;
    logic             two;
    logic [BUS_W-1:0] bus_a;
    logic [ID_W-1:0]  id_a;
    logic [BUS_W-1:0] bus_b;
    logic [ID_W-1:0]  id_b;
    logic [LEN_W-1:0] len;
    logic [PAY_W-1:0] payload;
    stat_t            stat;
  } job_t;

  typedef struct packed {
    logic             send;
    logic [BUS_W-1:0] bus;
    logic [ID_W-1:0]  id;
    logic [LEN_W-1:0] len;
    logic [PAY_W-1:0] payload;
    logic             last;
    stat_t            stat;
  } result_t;

  function automatic logic [7:0] crc_byte(input logic [7:0] crc_in, input logic [7:0] data,
                                          input logic [7:0] poly);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int j = 0; j < 8; j++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic is_diag(input logic [ID_W-1:0] id);
    logic hit;
    case (id)
      11'h315, 11'h118, 11'h266, 11'h126, 11'h3A5, 11'h1D6, ID_DIAG_IN: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic [ID_W-1:0] diag_id(input logic [ID_W-1:0] id);
    return (id == ID_DIAG_IN) ? ID_DIAG_OUT : id;
  endfunction

endpackage

/* src/ctf_front.sv */
// front part: input stage, frame classification, state update and edits
module ctf_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_action,
  input  logic [ctf_pkg::BUS_W-1:0]     in_source_bus,
  input  logic [ctf_pkg::ID_W-1:0]      in_rx_id,
  input  logic [ctf_pkg::LEN_W-1:0]     in_rx_length,
  input  logic [ctf_pkg::PAY_W-1:0]     in_rx_payload,
  input  logic [ctf_pkg::AGE_W-1:0]     timeout,
  input  logic [ctf_pkg::POLY_W-1:0]    poly,
  input  logic                          q_full,
  output logic                          q_push,
  output ctf_pkg::job_t                 q_job
);
  import ctf_pkg::*;

  logic             s1_vld_r;
  logic             s1_action_r;
  logic [BUS_W-1:0] s1_bus_r;
  logic [ID_W-1:0]  s1_id_r;
  logic [LEN_W-1:0] s1_len_r;
  logic [PAY_W-1:0] s1_pay_r;
  logic [7:0]       s1_crc_r;
  logic             s1_ready;

  logic             regen_r, regen_nxt;
  logic             allcut_r, allcut_nxt;
  logic [AGE_W-1:0] age_r, age_nxt;
  logic             pre_r, pre_nxt;
  logic             neg_r, neg_nxt;
  logic             pos_r, pos_nxt;

  assign s1_ready = !s1_vld_r || !q_full;
  assign in_full  = !s1_ready;
  assign q_push   = s1_vld_r && !q_full;

  // stage 1: register the item and run the crc over byte 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_ready) begin
      s1_vld_r <= in_push;
    end
    if (s1_ready && in_push) begin
      s1_action_r <= in_action;
      s1_bus_r    <= in_source_bus;
      s1_id_r     <= in_rx_id;
      s1_len_r    <= in_rx_length;
      s1_pay_r    <= in_rx_payload;
      s1_crc_r    <= crc_byte(CRC_INIT, in_rx_payload[7:0], poly);
    end
  end

  // stage 2: finish crc, update state, build the job
  always_comb begin
    logic [7:0]       crc;
    logic             fresh;
    logic             either;
    logic [PAY_W-1:0] p;
    logic [7:0]       sum;
    logic             diag;
    crc        = crc_byte(s1_crc_r, s1_pay_r[15:8], poly);
    fresh      = age_r < timeout;
    either     = regen_r || allcut_r;
    diag       = is_diag(s1_id_r);
    p          = s1_pay_r;
    sum        = 8'd0;
    regen_nxt  = regen_r;
    allcut_nxt = allcut_r;
    age_nxt    = age_r;
    pre_nxt    = pre_r;
    neg_nxt    = neg_r;
    pos_nxt    = pos_r;
    q_job      = '0;

    if (!s1_action_r) begin
      if (age_r != AGE_STALE) begin
        age_nxt = age_r + AGE_W'(1);
      end
    end else begin
      case (s1_bus_r)
        BUS_PT: begin
          if (s1_id_r == ID_RELAY_A || s1_id_r == ID_RELAY_B) begin
            q_job.send  = 1'b1;
            q_job.bus_a = BUS_CTL;
            q_job.id_a  = s1_id_r;
          end
          if (s1_id_r == ID_CUT && s1_len_r == LEN_CUT && crc == s1_pay_r[23:16]) begin
            regen_nxt  = s1_pay_r[0];
            allcut_nxt = s1_pay_r[1];
            age_nxt    = '0;
          end
          if (s1_id_r == ID_HV_CMD && s1_len_r == LEN_HV && s1_pay_r[7:0] == HV_HDR) begin
            if (s1_pay_r[15:8] == REQ_SET) begin
              pre_nxt = 1'b1;
            end else if (s1_pay_r[15:8] == REQ_CLR) begin
              pre_nxt = 1'b0;
            end
            if (s1_pay_r[23:16] == REQ_SET) begin
              neg_nxt = 1'b1;
            end else if (s1_pay_r[23:16] == REQ_CLR) begin
              neg_nxt = 1'b0;
            end
            if (s1_pay_r[31:24] == REQ_SET) begin
              pos_nxt = 1'b1;
            end else if (s1_pay_r[31:24] == REQ_CLR) begin
              pos_nxt = 1'b0;
            end
          end
        end
        BUS_CTL: begin
          q_job.send = 1'b1;
          if (s1_id_r == ID_DI && s1_len_r == LEN_DI) begin
            if (fresh && either) begin
              sum = p[7:0] + p[15:8] + p[23:16] + p[39:32] + p[47:40] + p[55:48]
                    + DI_SUM_BIAS;
              p[31:24] = 8'd0;
              p[63:56] = sum;
            end
            q_job.two   = 1'b1;
            q_job.bus_a = BUS_PT;
            q_job.id_a  = s1_id_r;
            q_job.bus_b = BUS_DU;
            q_job.id_b  = s1_id_r;
          end else if (s1_id_r == ID_PWR && s1_len_r == LEN_PWR) begin
            if (fresh && either) begin
              p[39:32] = PWR_LIMIT;
            end
            if (fresh && allcut_r) begin
              p[23:16] = 8'd0;
              p[24]    = 1'b0;
            end
            q_job.two   = 1'b1;
            q_job.bus_a = BUS_PT;
            q_job.id_a  = s1_id_r;
            q_job.bus_b = BUS_DU;
            q_job.id_b  = s1_id_r;
          end else begin
            q_job.two   = diag;
            q_job.bus_a = BUS_DU;
            q_job.id_a  = s1_id_r;
            q_job.bus_b = BUS_PT;
            q_job.id_b  = diag_id(s1_id_r);
          end
        end
        BUS_DU: begin
          q_job.send  = 1'b1;
          q_job.two   = diag;
          q_job.bus_a = BUS_CTL;
          q_job.id_a  = s1_id_r;
          q_job.bus_b = BUS_PT;
          q_job.id_b  = diag_id(s1_id_r);
        end
        default: begin
        end
      endcase
    end

    if (q_job.send) begin
      q_job.len     = s1_len_r;
      q_job.payload = p;
    end
    q_job.stat.precharge = pre_nxt;
    q_job.stat.negative  = neg_nxt;
    q_job.stat.positive  = pos_nxt;
    q_job.stat.clamp     = (age_nxt < timeout) && (regen_nxt || allcut_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regen_r  <= 1'b0;
      allcut_r <= 1'b0;
      age_r    <= AGE_STALE;
      pre_r    <= 1'b0;
      neg_r    <= 1'b0;
      pos_r    <= 1'b0;
    end else if (q_push) begin
      regen_r  <= regen_nxt;
      allcut_r <= allcut_nxt;
      age_r    <= age_nxt;
      pre_r    <= pre_nxt;
      neg_r    <= neg_nxt;
      pos_r    <= pos_nxt;
    end
  end

endmodule

/* src/ctf_queue.sv */
// short job queue between the front and back parts
module ctf_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ctf_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output ctf_pkg::job_t head_job
);
  import ctf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = cnt_r == CNT_W'(DEPTH);
  assign empty    = cnt_r == '0;
  assign head_job = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* src/ctf_back.sv */
// back part: expands jobs into one or two results behind an output register
module ctf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  ctf_pkg::job_t  q_job,
  output logic           q_pop,
  input  logic           out_pop,
  output logic           out_empty,
  output ctf_pkg::result_t out_res
);
  import ctf_pkg::*;

  logic    out_vld_r, out_vld_nxt;
  logic    phase_r, phase_nxt;
  result_t res_r;
  result_t res_nxt;
  logic    load;
  logic    take;

  assign load      = !out_vld_r || out_pop;
  assign take      = load && !q_empty;
  assign out_empty = !out_vld_r;
  assign out_res   = res_r;

  always_comb begin
    res_nxt         = '0;
    res_nxt.send    = q_job.send;
    res_nxt.bus     = phase_r ? q_job.bus_b : q_job.bus_a;
    res_nxt.id      = phase_r ? q_job.id_b : q_job.id_a;
    res_nxt.len     = q_job.len;
    res_nxt.payload = q_job.payload;
    res_nxt.last    = !q_job.two || phase_r;
    res_nxt.stat    = q_job.stat;
    q_pop           = take && res_nxt.last;
    phase_nxt       = take ? (q_job.two && !phase_r) : phase_r;
    out_vld_nxt     = load ? !q_empty : out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      phase_r   <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      phase_r   <= phase_nxt;
    end
    if (take) begin
      res_r <= res_nxt;
    end
  end

endmodule

/* src/can_gateway_torque_cut_filter.sv */
// top level of the three-bus gateway torque cut filter
//
// input queue port: an item (tick or received frame) is taken when in_push is
// high and in_full is low. result queue port: the oldest result sits on the
// out_ ports while out_empty is low and leaves when out_pop is high.
// every item gives one result (send_valid low for ticks and dropped frames)
// or two results for forwarded frames that go to two buses; last_of_run marks
// the final result of an item. cfg_ is a write port, always ready, index 0 is
// the cut timeout in ms and index 1 the crc8 polynomial; write it while idle.
// a result passes the stage 1 register, the job queue and the output register
// to the out_ ports. the front stage takes one item per cycle while in_full
// is low; the back stage drives one result per cycle while out_empty or
// out_pop is high. a job queue of QUEUE_DEPTH entries lets the front keep
// working while the receiver stalls; in_full rises once it and stage 1 are
// full. reset clears the flags, requests and queues, sets the cut age to
// stale and loads the default timeout of 150 ms and polynomial 0xd5.
module can_gateway_torque_cut_filter #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic                              in_action,
  input  logic [ctf_pkg::BUS_W-1:0]         in_source_bus,
  input  logic [ctf_pkg::ID_W-1:0]          in_rx_id,
  input  logic [ctf_pkg::LEN_W-1:0]         in_rx_length,
  input  logic [ctf_pkg::PAY_W-1:0]         in_rx_payload,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic                              out_send_valid,
  output logic [ctf_pkg::BUS_W-1:0]         out_dest_bus,
  output logic [ctf_pkg::ID_W-1:0]          out_tx_id,
  output logic [ctf_pkg::LEN_W-1:0]         out_tx_length,
  output logic [ctf_pkg::PAY_W-1:0]         out_tx_payload,
  output logic                              out_last_of_run,
  output logic                              out_precharge_on,
  output logic                              out_negative_main_on,
  output logic                              out_positive_main_on,
  output logic                              out_regen_clamp_active,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ctf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ctf_pkg::CFG_DAT_W-1:0]     cfg_data
);
  import ctf_pkg::*;

  logic [AGE_W-1:0]  timeout_r;
  logic [POLY_W-1:0] poly_r;
  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_empty;
  job_t              push_job;
  job_t              head_job;
  result_t           res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      poly_r    <= POLY_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TIMEOUT: timeout_r <= cfg_data;
        CFG_POLY:    poly_r    <= cfg_data[POLY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ctf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_action     (in_action),
    .in_source_bus (in_source_bus),
    .in_rx_id      (in_rx_id),
    .in_rx_length  (in_rx_length),
    .in_rx_payload (in_rx_payload),
    .timeout       (timeout_r),
    .poly          (poly_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (push_job)
  );

  ctf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_job (head_job)
  );

  ctf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (head_job),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_res   (res)
  );

  assign out_send_valid         = res.send;
  assign out_dest_bus           = res.bus;
  assign out_tx_id              = res.id;
  assign out_tx_length          = res.len;
  assign out_tx_payload         = res.payload;
  assign out_last_of_run        = res.last;
  assign out_precharge_on       = res.stat.precharge;
  assign out_negative_main_on   = res.stat.negative;
  assign out_positive_main_on   = res.stat.positive;
  assign out_regen_clamp_active = res.stat.clamp;

endmodule
